// ===== rtl/tkk_pkg.sv =====
// shared types and widths for the top-k learner keeper
// no dependencies; imported by every module of the block
package tkk_pkg;

  localparam int FEAT_W = 16;
  localparam int DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FEAT_W-1:0]        feature;
    logic signed [DATA_W-1:0] threshold;
    logic signed [DATA_W-1:0] weight;
    logic                     has_learner;
    logic                     batch_end;
  } item_t;

endpackage

// ===== rtl/tkk_front.sv =====
// front end: request acceptance, filtering of empty requests, two-entry queue
// depends on tkk_pkg
module tkk_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tkk_pkg::FEAT_W-1:0]          in_feature,
  input  logic signed [tkk_pkg::DATA_W-1:0]   in_threshold,
  input  logic signed [tkk_pkg::DATA_W-1:0]   in_weight,
  input  logic                                in_has_learner,
  input  logic                                in_batch_end,
  output tkk_pkg::item_t                      head,
  output logic                                head_valid,
  input  logic                                pop
);
  import tkk_pkg::*;

  item_t       q_mem_r [QUEUE_DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        do_pop;
  item_t       new_item;

  assign busy       = (cnt_r == 2'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_mem_r[rd_ptr_r];

  // requests with neither a learner nor a batch end leave no trace
  assign push   = start && !busy && (in_has_learner || in_batch_end);
  assign do_pop = pop && head_valid;

  always_comb begin
    new_item.feature     = in_feature;
    new_item.threshold   = in_threshold;
    new_item.weight      = in_weight;
    new_item.has_learner = in_has_learner;
    new_item.batch_end   = in_batch_end;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== rtl/tkk_back.sv =====
// back end: sorted row of kept learners, parallel insertion, rotating list readout
// depends on tkk_pkg; fed by the tkk_front queue
module tkk_back #(
  parameter int TOP_COUNT = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tkk_pkg::item_t                      head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                out_strobe,
  output logic [tkk_pkg::FEAT_W-1:0]          out_feature,
  output logic signed [tkk_pkg::DATA_W-1:0]   out_threshold,
  output logic signed [tkk_pkg::DATA_W-1:0]   out_weight,
  output logic                                out_entry_valid,
  output logic                                out_list_end
);
  import tkk_pkg::*;

  localparam int CNT_W = $clog2(TOP_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          rot_r, rot_nxt;

  logic [FEAT_W-1:0]         feat_r [TOP_COUNT];
  logic signed [DATA_W-1:0]  thr_r  [TOP_COUNT];
  logic signed [DATA_W-1:0]  w_r    [TOP_COUNT];
  logic [FEAT_W-1:0]         feat_nxt [TOP_COUNT];
  logic signed [DATA_W-1:0]  thr_nxt  [TOP_COUNT];
  logic signed [DATA_W-1:0]  w_nxt    [TOP_COUNT];

  logic [FEAT_W-1:0]         feat_rot [TOP_COUNT];
  logic signed [DATA_W-1:0]  thr_rot  [TOP_COUNT];
  logic signed [DATA_W-1:0]  w_rot    [TOP_COUNT];
  logic [FEAT_W-1:0]         feat_prv [TOP_COUNT];
  logic signed [DATA_W-1:0]  thr_prv  [TOP_COUNT];
  logic signed [DATA_W-1:0]  w_prv    [TOP_COUNT];
  logic [TOP_COUNT-1:0]      ge;
  logic [TOP_COUNT-1:0]      ge_prv;

  logic                      do_ins;
  logic                      do_rot;

  logic                      strobe_r, strobe_nxt;
  logic [FEAT_W-1:0]         o_feat_r, o_feat_nxt;
  logic signed [DATA_W-1:0]  o_thr_r, o_thr_nxt;
  logic signed [DATA_W-1:0]  o_w_r, o_w_nxt;
  logic                      o_valid_r, o_valid_nxt;
  logic                      o_end_r, o_end_nxt;

  // per-cell compare and neighbor wiring
  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < cnt_r) && (w_r[i] >= head.weight);
    if (i == TOP_COUNT - 1) begin : g_last
      assign feat_rot[i] = feat_r[0];
      assign thr_rot[i]  = thr_r[0];
      assign w_rot[i]    = w_r[0];
    end else begin : g_mid
      assign feat_rot[i] = feat_r[i+1];
      assign thr_rot[i]  = thr_r[i+1];
      assign w_rot[i]    = w_r[i+1];
    end
    if (i == 0) begin : g_first
      assign ge_prv[i]   = 1'b1;
      assign feat_prv[i] = head.feature;
      assign thr_prv[i]  = head.threshold;
      assign w_prv[i]    = head.weight;
    end else begin : g_rest
      assign ge_prv[i]   = ge[i-1];
      assign feat_prv[i] = feat_r[i-1];
      assign thr_prv[i]  = thr_r[i-1];
      assign w_prv[i]    = w_r[i-1];
    end
  end

  assign pop    = (state_r == ST_IDLE) && head_valid;
  assign do_ins = pop && head.has_learner;
  assign do_rot = (state_r == ST_EMIT);

  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      feat_nxt[i] = feat_r[i];
      thr_nxt[i]  = thr_r[i];
      w_nxt[i]    = w_r[i];
      if (do_rot) begin
        feat_nxt[i] = feat_rot[i];
        thr_nxt[i]  = thr_rot[i];
        w_nxt[i]    = w_rot[i];
      end else if (do_ins && !ge[i]) begin
        if (ge_prv[i]) begin
          // insertion point
          feat_nxt[i] = head.feature;
          thr_nxt[i]  = head.threshold;
          w_nxt[i]    = head.weight;
        end else begin
          feat_nxt[i] = feat_prv[i];
          thr_nxt[i]  = thr_prv[i];
          w_nxt[i]    = w_prv[i];
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rot_nxt     = rot_r;
    strobe_nxt  = 1'b0;
    o_feat_nxt  = feat_r[0];
    o_thr_nxt   = thr_r[0];
    o_w_nxt     = w_r[0];
    o_valid_nxt = 1'b1;
    o_end_nxt   = (rot_r == cnt_r - CNT_W'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (do_ins && cnt_r != CNT_W'(TOP_COUNT)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (pop && head.batch_end) begin
          if (cnt_r == '0 && !head.has_learner) begin
            // empty list
            strobe_nxt  = 1'b1;
            o_feat_nxt  = '0;
            o_thr_nxt   = '0;
            o_w_nxt     = '0;
            o_valid_nxt = 1'b0;
            o_end_nxt   = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
            rot_nxt   = '0;
          end
        end
      end
      ST_EMIT: begin
        strobe_nxt = (rot_r < cnt_r);
        rot_nxt    = rot_r + CNT_W'(1);
        if (rot_r == CNT_W'(TOP_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rot_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rot_r    <= rot_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      feat_r[i] <= feat_nxt[i];
      thr_r[i]  <= thr_nxt[i];
      w_r[i]    <= w_nxt[i];
    end
    o_feat_r  <= o_feat_nxt;
    o_thr_r   <= o_thr_nxt;
    o_w_r     <= o_w_nxt;
    o_valid_r <= o_valid_nxt;
    o_end_r   <= o_end_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_feature     = o_feat_r;
  assign out_threshold   = o_thr_r;
  assign out_weight      = o_w_r;
  assign out_entry_valid = o_valid_r;
  assign out_list_end    = o_end_r;

endmodule

// ===== rtl/top_k_learner_keeper.sv =====
// top-k learner keeper: queue front end feeding the sorted keep list
// the first result of a batch passes the queue, the insert step and the output register;
// an empty list skips the insert step; later results follow one per cycle
// throughput: one request per cycle into the queue while busy is low; a learner is inserted
// as it is popped, a batch end holds the back end for its pop plus a full list rotation,
// during which no request is popped; results never stall. busy rises while the two-entry
// queue is full; synchronous active-low reset empties the queue and the kept list
module top_k_learner_keeper #(
  parameter int TOP_COUNT = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tkk_pkg::FEAT_W-1:0]          in_feature,
  input  logic signed [tkk_pkg::DATA_W-1:0]   in_threshold,
  input  logic signed [tkk_pkg::DATA_W-1:0]   in_weight,
  input  logic                                in_has_learner,
  input  logic                                in_batch_end,
  output logic                                out_strobe,
  output logic [tkk_pkg::FEAT_W-1:0]          out_feature,
  output logic signed [tkk_pkg::DATA_W-1:0]   out_threshold,
  output logic signed [tkk_pkg::DATA_W-1:0]   out_weight,
  output logic                                out_entry_valid,
  output logic                                out_list_end
);
  import tkk_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  tkk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_feature     (in_feature),
    .in_threshold   (in_threshold),
    .in_weight      (in_weight),
    .in_has_learner (in_has_learner),
    .in_batch_end   (in_batch_end),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  tkk_back #(
    .TOP_COUNT (TOP_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_feature     (out_feature),
    .out_threshold   (out_threshold),
    .out_weight      (out_weight),
    .out_entry_valid (out_entry_valid),
    .out_list_end    (out_list_end)
  );

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |-> out_list_end)
    else $error("empty-list result without list end");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |->
      out_feature == '0 && out_threshold == '0 && out_weight == '0)
    else $error("empty-list result carries data");

  a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_entry_valid && !out_list_end |=>
      out_strobe && out_entry_valid && out_weight <= $past(out_weight))
    else $error("kept list out of order or broken");

endmodule
